/* sv/rsap_pkg.sv */
// shared types and constants of the run-length sprite alpha probe
package rsap_pkg;

	localparam int unsigned SIDE_W = 12;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = 2;

	// queue entry kinds
	localparam logic [1:0] KIND_REJECT = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;

	// back-end phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_COUNT = 2'd1;
	localparam logic [1:0] PH_ALPHA = 2'd2;
	localparam logic [1:0] PH_SKIP  = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SIDE_W-1:0] col;
		logic [SIDE_W-1:0] row;
		logic [SIDE_W-1:0] width;
		logic [7:0]        data;
	} rsap_entry_t;

endpackage

/* sv/rsap_front.sv */
// front end: config register, query geometry check and item classification
module rsap_front #(
	parameter int unsigned MAX_SIDE = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic signed [15:0]   frame_index,
	input  logic signed [15:0]   query_x,
	input  logic signed [15:0]   query_y,
	input  logic signed [15:0]   offset_x,
	input  logic signed [15:0]   offset_y,
	input  logic [11:0]          frame_width,
	input  logic [11:0]          frame_height,
	input  logic [7:0]           data_byte,
	input  logic                 q_full,
	output logic                 q_push,
	output rsap_pkg::rsap_entry_t q_entry
);
	import rsap_pkg::*;

	localparam logic [16:0] SideLimit = 17'(MAX_SIDE);
	localparam logic [SIDE_W-1:0] SideMax = SIDE_W'(MAX_SIDE - 1);

	logic [15:0]       frame_count_q;
	logic [16:0]       rx;
	logic [16:0]       ry;
	logic [SIDE_W-1:0] w_sat;
	logic [SIDE_W-1:0] h_sat;
	logic              idx_bad;
	logic              x_bad;
	logic              y_bad;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (cfg_valid) begin
			frame_count_q <= cfg_data;
		end
	end

	always_comb begin
		w_sat = ({5'b0, frame_width} < SideLimit) ? frame_width : SideMax;
		h_sat = ({5'b0, frame_height} < SideLimit) ? frame_height : SideMax;
		rx = {query_x[15], query_x} - {offset_x[15], offset_x};
		ry = {query_y[15], query_y} - {offset_y[15], offset_y};
		idx_bad = frame_index[15] || ($unsigned(frame_index) >= frame_count_q);
		x_bad = rx[16] || (rx[15:0] >= {4'b0, w_sat});
		y_bad = ry[16] || (ry[15:0] >= {4'b0, h_sat});
	end

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		q_entry.col = rx[SIDE_W-1:0];
		q_entry.row = ry[SIDE_W-1:0];
		q_entry.width = w_sat;
		q_entry.data = data_byte;
		if (operation) begin
			q_entry.kind = KIND_DATA;
		end else if (idx_bad || x_bad || y_bad) begin
			q_entry.kind = KIND_REJECT;
		end else begin
			q_entry.kind = KIND_START;
		end
	end

endmodule

/* sv/rsap_queue.sv */
// short register queue between front and back end
module rsap_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rsap_pkg::rsap_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output rsap_pkg::rsap_entry_t head_entry
);
	import rsap_pkg::*;

	rsap_entry_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		QPTR_W'(wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0])
		else $error("queue pointers disagree with count");

endmodule

/* sv/rsap_back.sv */
// back end: walks the run-length stream and holds the result register
module rsap_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  rsap_pkg::rsap_entry_t q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            alpha,
	output logic                  inside_res
);
	import rsap_pkg::*;

	logic [1:0]        phase_q;
	logic [SIDE_W-1:0] rows_to_skip_q;
	logic [SIDE_W-1:0] row_left_q;
	logic [SIDE_W-1:0] target_col_q;
	logic [SIDE_W-1:0] row_width_q;
	logic [7:0]        run_len_q;
	logic [7:0]        skip_left_q;
	logic              on_row_q;
	logic              out_valid_q;
	logic [7:0]        alpha_q;
	logic              inside_q;
	logic [SIDE_W-1:0] run_ext;
	logic [SIDE_W-1:0] rows_dec;
	logic [7:0]        skip_dec;

	assign q_pop = !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign alpha = alpha_q;
	assign inside_res = inside_q;

	assign run_ext = {{(SIDE_W-8){1'b0}}, run_len_q};
	assign rows_dec = rows_to_skip_q - 1'b1;
	assign skip_dec = skip_left_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rows_to_skip_q <= '0;
			row_left_q <= '0;
			target_col_q <= '0;
			row_width_q <= '0;
			run_len_q <= '0;
			skip_left_q <= '0;
			on_row_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (q_head.kind)
					KIND_REJECT: begin
						phase_q <= PH_IDLE;
						out_valid_q <= 1'b1;
					end
					KIND_START: begin
						row_width_q <= q_head.width;
						target_col_q <= q_head.col;
						rows_to_skip_q <= q_head.row;
						run_len_q <= '0;
						skip_left_q <= '0;
						on_row_q <= (q_head.row == '0);
						row_left_q <= (q_head.row == '0) ? q_head.col : q_head.width;
						phase_q <= PH_COUNT;
					end
					KIND_DATA: begin
						case (phase_q)
							PH_COUNT: begin
								run_len_q <= q_head.data;
								phase_q <= PH_ALPHA;
							end
							PH_ALPHA: begin
								if (on_row_q && (run_ext > row_left_q)) begin
									phase_q <= PH_IDLE;
									out_valid_q <= 1'b1;
								end else begin
									if (!on_row_q && (run_ext >= row_left_q)) begin
										rows_to_skip_q <= rows_dec;
										if (rows_dec == '0) begin
											on_row_q <= 1'b1;
											row_left_q <= target_col_q;
										end else begin
											row_left_q <= row_width_q;
										end
									end else begin
										row_left_q <= row_left_q - run_ext;
									end
									if ((q_head.data != 8'd0) && (run_len_q != 8'd0)) begin
										skip_left_q <= run_len_q;
										phase_q <= PH_SKIP;
									end else begin
										phase_q <= PH_COUNT;
									end
								end
							end
							PH_SKIP: begin
								skip_left_q <= skip_dec;
								if (skip_dec == 8'd0) begin
									phase_q <= PH_COUNT;
								end
							end
							default: begin
								phase_q <= phase_q;
							end
						endcase
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (q_pop && (q_head.kind == KIND_REJECT)) begin
			alpha_q <= 8'd0;
			inside_q <= 1'b0;
		end else if (q_pop && (q_head.kind == KIND_DATA) && (phase_q == PH_ALPHA)
				&& on_row_q && (run_ext > row_left_q)) begin
			alpha_q <= q_head.data;
			inside_q <= 1'b1;
		end
	end

	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(q_pop)) else $error("result without a queue pop");
	a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !q_pop) else $error("pop while result stalled");
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_left_q != 8'd0)) else $error("skip phase with zero count");
	a_reject_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.kind == KIND_REJECT) |=> (out_valid_q && !inside_q && phase_q == PH_IDLE))
		else $error("reject did not answer zero");

endmodule

/* sv/rle_sprite_alpha_probe_top.sv */
// top level of the run-length sprite alpha probe
//
// in channel (in_valid/in_ready): operation 0 begins a query with the frame
// index, query point, frame offset and frame size; operation 1 transfers one
// coded byte of the selected frame. out channel (out_valid/out_ready) returns
// alpha and inside_res: at once (alpha 0, inside_res 0) for a rejected query,
// otherwise after the alpha byte of the run covering the queried column.
// cfg channel (cfg_valid/cfg_ready, always ready) writes frame_count; write it
// only while the block is idle.
// a result passes through a queue slot and the result register after the
// transfer of the item that caused it. one item per cycle is sustained while
// no result is stalled: the front end classifies each item in the cycle it
// arrives and pushes it into a four-entry queue, the back end executes one
// queue entry per cycle against its run counters. when out_ready is low the
// back end holds its result and stops popping; the front keeps taking items
// until the queue is full, then drops in_ready. reset clears frame_count, the
// queue pointers and the result valid flag; the block is ready once reset ends.
module rle_sprite_alpha_probe_top #(
	parameter int unsigned MAX_SIDE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [15:0] frame_index,
	input  logic signed [15:0] query_x,
	input  logic signed [15:0] query_y,
	input  logic signed [15:0] offset_x,
	input  logic signed [15:0] offset_y,
	input  logic [11:0]        frame_width,
	input  logic [11:0]        frame_height,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         alpha,
	output logic               inside_res
);
	import rsap_pkg::*;

	rsap_entry_t push_entry;
	rsap_entry_t head_entry;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;

	rsap_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.frame_index(frame_index),
		.query_x(query_x),
		.query_y(query_y),
		.offset_x(offset_x),
		.offset_y(offset_y),
		.frame_width(frame_width),
		.frame_height(frame_height),
		.data_byte(data_byte),
		.q_full(q_full),
		.q_push(q_push),
		.q_entry(push_entry)
	);

	rsap_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(push_entry),
		.full(q_full),
		.pop(q_pop),
		.empty(q_empty),
		.head_entry(head_entry)
	);

	rsap_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(head_entry),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.alpha(alpha),
		.inside_res(inside_res)
	);

endmodule

/* tb/tb_rle_sprite_alpha_probe_top.sv */
// self-checking testbench for the run-length sprite alpha probe: directed cases, then random queries
module tb_rle_sprite_alpha_probe_top;
	import rsap_pkg::*;

	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_DATA  = 1'b1;
	localparam int   MAX_SIDE = 4096;
	localparam int   SETTLE_CYCLES = 12;
	localparam int   ITEMS_PER_PHASE = 190;

	typedef struct {
		logic               op;
		logic signed [15:0] fidx;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] ox;
		logic signed [15:0] oy;
		logic [11:0]        fw;
		logic [11:0]        fh;
		logic [7:0]         dat;
	} probe_item_t;

	typedef struct {
		logic [7:0] alpha;
		logic       in_frame;
	} alpha_result_t;

	class alpha_probe_tracker;
		logic [15:0]   frame_count;
		logic [1:0]    phase;
		logic [11:0]   rows_left;
		logic [12:0]   row_left;
		logic [11:0]   target_col;
		logic [11:0]   row_width;
		logic [7:0]    run_len;
		logic [7:0]    skip_left;
		bit            on_row;
		alpha_result_t expected_alphas[$];
		int            live_items;
		int            results_seen;
		int            mismatches;

		function new();
			frame_count = '0;
			phase = PH_IDLE;
			rows_left = '0;
			row_left = '0;
			target_col = '0;
			row_width = '0;
			run_len = '0;
			skip_left = '0;
			on_row = 1'b0;
			live_items = 0;
			results_seen = 0;
			mismatches = 0;
		endfunction

		function void push_alpha(logic [7:0] a, logic ins);
			alpha_result_t e;
			e.alpha = a;
			e.in_frame = ins;
			expected_alphas.push_back(e);
		endfunction

		function int clamp_side(logic [11:0] v);
			return (int'(v) < MAX_SIDE) ? int'(v) : MAX_SIDE - 1;
		endfunction

		// predicts the block for one accepted input transfer
		function void note_item(probe_item_t it);
			int rx;
			int ry;
			int w;
			int h;
			if (it.op == OP_BEGIN || phase != PH_IDLE)
				live_items++;
			if (it.op == OP_BEGIN) begin
				rx = int'(it.qx) - int'(it.ox);
				ry = int'(it.qy) - int'(it.oy);
				w = clamp_side(it.fw);
				h = clamp_side(it.fh);
				phase = PH_IDLE;
				if (it.fidx < 0 || int'(it.fidx) >= int'(frame_count) ||
				    rx < 0 || rx >= w || ry < 0 || ry >= h) begin
					push_alpha(8'd0, 1'b0);
					return;
				end
				row_width = 12'(w);
				target_col = 12'(rx);
				rows_left = 12'(ry);
				run_len = '0;
				skip_left = '0;
				if (ry == 0) begin
					on_row = 1'b1;
					row_left = {1'b0, target_col};
				end else begin
					on_row = 1'b0;
					row_left = {1'b0, row_width};
				end
				phase = PH_COUNT;
				return;
			end
			case (phase)
				PH_COUNT: begin
					run_len = it.dat;
					phase = PH_ALPHA;
				end
				PH_ALPHA: begin
					if (on_row) begin
						if (run_len > row_left) begin
							phase = PH_IDLE;
							push_alpha(it.dat, 1'b1);
							return;
						end
						row_left = row_left - {5'd0, run_len};
					end else if (run_len >= row_left) begin
						// row finished, surplus of the run is dropped
						rows_left = rows_left - 12'd1;
						if (rows_left == 0) begin
							on_row = 1'b1;
							row_left = {1'b0, target_col};
						end else begin
							row_left = {1'b0, row_width};
						end
					end else begin
						row_left = row_left - {5'd0, run_len};
					end
					if (it.dat != 0 && run_len != 0) begin
						skip_left = run_len;
						phase = PH_SKIP;
					end else begin
						phase = PH_COUNT;
					end
				end
				PH_SKIP: begin
					skip_left = skip_left - 8'd1;
					if (skip_left == 0)
						phase = PH_COUNT;
				end
				default: ;
			endcase
		endfunction

		function void check_alpha(logic [7:0] a, logic ins);
			alpha_result_t e;
			results_seen++;
			if (expected_alphas.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: alpha %02h inside_res %0b", a, ins);
				return;
			end
			e = expected_alphas.pop_front();
			if (e.alpha !== a || e.in_frame !== ins) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected alpha %02h inside_res %0b, got alpha %02h inside_res %0b",
						e.alpha, e.in_frame, a, ins);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               operation;
	logic signed [15:0] frame_index;
	logic signed [15:0] query_x;
	logic signed [15:0] query_y;
	logic signed [15:0] offset_x;
	logic signed [15:0] offset_y;
	logic [11:0]        frame_width;
	logic [11:0]        frame_height;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         alpha;
	logic               inside_res;

	alpha_probe_tracker sb = new();
	bit in_idle_on;
	bit out_stall_on;
	int stall_left = 0;
	int cfg_writes;

	rle_sprite_alpha_probe_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.frame_index (frame_index),
		.query_x     (query_x),
		.query_y     (query_y),
		.offset_x    (offset_x),
		.offset_y    (offset_y),
		.frame_width (frame_width),
		.frame_height(frame_height),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.alpha       (alpha),
		.inside_res  (inside_res)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: check each transfer, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_alpha(alpha, inside_res);
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (out_stall_on && $urandom_range(0, 3) == 0) begin
			stall_left = pick_pause() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic probe_item_t rand_item();
		probe_item_t it;
		it.op = OP_DATA;
		it.fidx = 16'($urandom);
		it.qx = 16'($urandom);
		it.qy = 16'($urandom);
		it.ox = 16'($urandom);
		it.oy = 16'($urandom);
		it.fw = 12'($urandom);
		it.fh = 12'($urandom);
		it.dat = 8'($urandom);
		return it;
	endfunction

	task automatic send_item(input probe_item_t it);
		int gap;
		gap = (in_idle_on && $urandom_range(0, 1) == 1) ? pick_pause() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		frame_index <= it.fidx;
		query_x <= it.qx;
		query_y <= it.qy;
		offset_x <= it.ox;
		offset_y <= it.oy;
		frame_width <= it.fw;
		frame_height <= it.fh;
		data_byte <= it.dat;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
	endtask

	task automatic send_begin(input int idx, input int qx, input int qy, input int ox,
		input int oy, input int w, input int h);
		probe_item_t it;
		it = rand_item();
		it.op = OP_BEGIN;
		it.fidx = 16'(idx);
		it.qx = 16'(qx);
		it.qy = 16'(qy);
		it.ox = 16'(ox);
		it.oy = 16'(oy);
		it.fw = 12'(w);
		it.fh = 12'(h);
		send_item(it);
	endtask

	task automatic send_data(input logic [7:0] d);
		probe_item_t it;
		it = rand_item();
		it.dat = d;
		send_item(it);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_alphas.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_frame_count(input logic [15:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.frame_count = v;
		cfg_writes++;
	endtask

	// next coded byte that fits where the frame stream currently stands
	function automatic logic [7:0] next_rle_byte(input int w);
		int r;
		r = $urandom_range(0, 99);
		if (sb.phase == PH_COUNT) begin
			if (w > 64 && r < 70)
				return 8'($urandom_range(128, 255));
			if (r < 10)
				return 8'd0;
			if (r < 20)
				return 8'($urandom_range(200, 255));
			if (r < 70)
				return 8'($urandom_range(1, 4));
			return 8'($urandom_range(1, (w + 2 > 255) ? 255 : w + 2));
		end
		if (sb.phase == PH_ALPHA) begin
			if (sb.run_len > 32 && r < 85)
				return 8'd0;
			if (r < 35)
				return 8'd0;
			if (r < 45)
				return 8'hFF;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic run_query(input bit broken, input int room);
		int fc;
		int w;
		int h;
		int rx;
		int ry;
		int ox;
		int oy;
		int idx;
		int cap;
		int n;
		int r;
		fc = int'(sb.frame_count);
		w = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 4095);
		h = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 4095) : $urandom_range(1, 16);
		rx = $urandom_range(0, w - 1);
		if (w > 24)
			ry = $urandom_range(0, (h > 1) ? 1 : 0);
		else
			ry = $urandom_range(0, ((h < 16) ? h : 16) - 1);
		r = $urandom_range(0, 19);
		if (r == 0)
			rx = -1;
		else if (r == 1)
			rx = w;
		else if (r == 2)
			ry = -1;
		else if (r == 3)
			ry = h;
		if (fc > 0)
			idx = $urandom_range(0, (fc - 1 > 32767) ? 32767 : fc - 1);
		else
			idx = $urandom_range(0, 15);
		if ($urandom_range(0, 9) == 0 && fc <= 32767)
			idx = fc;
		ox = $urandom_range(0, 58000) - 30000;
		oy = $urandom_range(0, 58000) - 30000;
		send_begin(idx, ox + rx, oy + ry, ox, oy, w, h);
		// a stream cut short by the item budget leaves the query open
		cap = broken ? $urandom_range(0, 12) : ((room > 0) ? room : 0);
		n = 0;
		while (sb.phase != PH_IDLE && n < cap) begin
			send_data(next_rle_byte(w));
			n++;
		end
	endtask

	initial begin
		logic [15:0] cfg_plan [5];
		probe_item_t it;
		int r;
		int start;
		cfg_plan = '{16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd3};
		cfg_plan[3] = 16'($urandom_range(2, 65534));
		cfg_writes = 0;
		in_idle_on = 1'b1;
		out_stall_on = 1'b1;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		operation <= OP_BEGIN;
		frame_index <= '0;
		query_x <= '0;
		query_y <= '0;
		offset_x <= '0;
		offset_y <= '0;
		frame_width <= '0;
		frame_height <= '0;
		data_byte <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_frame_count(16'd8);
		// rejected queries: bad frame numbers, empty frames, point off the frame
		send_begin(-32768, 0, 0, 0, 0, 10, 10);
		send_begin(8, 2, 2, 0, 0, 10, 10);
		send_begin(32767, 32767, 32767, -32768, -32768, 4095, 4095);
		send_begin(0, 3, 3, 0, 0, 0, 10);
		send_begin(1, 3, 3, 0, 0, 10, 0);
		send_begin(2, -32768, 0, 32767, 0, 10, 10);
		// coded byte with no query open
		send_data(8'hFF);
		// column on a run boundary belongs to the next run
		send_begin(3, 4, 0, 0, 0, 8, 3);
		send_data(8'd4);
		send_data(8'd0);
		send_data(8'd4);
		send_data(8'h22);
		// run spilling past the end of a skipped row
		send_begin(4, 1, 1, 0, 0, 4, 3);
		send_data(8'd6);
		send_data(8'd0);
		send_data(8'd2);
		send_data(8'hFF);
		// new query abandons an open one; zero-length run on the target row
		send_begin(5, 0, 1, 0, 0, 4, 2);
		send_data(8'd3);
		send_begin(7, 32767, -32768, 32767, -32768, 4095, 4095);
		send_data(8'd0);
		send_data(8'h80);
		send_data(8'd255);
		send_data(8'hFF);

		for (int p = 0; p < 5; p++) begin
			wait_drained();
			write_frame_count(cfg_plan[p]);
			start = sb.live_items;
			while (sb.live_items - start < ITEMS_PER_PHASE) begin
				in_idle_on = ($urandom_range(0, 3) != 0);
				out_stall_on = ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 99);
				if (r < 3) begin
					wait_drained();
				end else if (r < 70) begin
					run_query(1'b0, ITEMS_PER_PHASE - (sb.live_items - start));
				end else if (r < 80) begin
					it = rand_item();
					it.op = OP_BEGIN;
					send_item(it);
				end else if (r < 88) begin
					send_data(8'($urandom));
				end else begin
					run_query(1'b1, ITEMS_PER_PHASE - (sb.live_items - start));
				end
			end
		end

		wait_drained();
		$display("covered %0d input transfers and %0d result transfers over %0d frame_count writes",
			sb.live_items, sb.results_seen, cfg_writes);
		$display("frame_count settings included 0 and 65535; %0d mismatches", sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_alphas.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#8000000;
		$display("timeout: results still outstanding");
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
sv/rsap_pkg.sv
sv/rsap_front.sv
sv/rsap_queue.sv
sv/rsap_back.sv
sv/rle_sprite_alpha_probe_top.sv
tb/tb_rle_sprite_alpha_probe_top.sv
